[rtl/core/spim0_pkg.sv]
`timescale 1ns / 1ps
// Package for the mode-0 SPI master core: widths, phase codes and the
// request, result and status structs. No dependencies.
package spim0_pkg;

	localparam int BITS_PER_WORD = 8;
	localparam int HALF_W        = 16;
	localparam int BYTE_W        = 8;
	localparam int PHASE_W       = 3;
	localparam int BIT_IDX_W     = $clog2(BITS_PER_WORD);

	localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SETUP = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LOW   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_HIGH  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CLOSE = 3'd4;

	localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_WORD - 1);

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] tx_byte;
		logic              drive_out;
		logic              open_frame;
		logic              close_frame;
		logic              miso;
	} req_t;

	typedef struct packed {
		logic              sclk;
		logic              mosi;
		logic              cs_n;
		logic              ready_res;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_valid;
	} res_t;

	typedef struct packed {
		logic busy;      // phase is not idle
		logic delay_nz;  // delay counter is non-zero
	} eng_status_t;

endpackage

[rtl/core/spim0_ifs.sv]
`timescale 1ns / 1ps
// Channel interfaces of the SPI master core: request, result and config.
// Depends on spim0_pkg for widths.
interface spim0_req_if;
	import spim0_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] tx_byte;
	logic              drive_out;
	logic              open_frame;
	logic              close_frame;
	logic              miso;

	modport source (output valid, kind, tx_byte, drive_out, open_frame, close_frame, miso,
		input ready);
	modport sink (input valid, kind, tx_byte, drive_out, open_frame, close_frame, miso,
		output ready);
endinterface

interface spim0_res_if;
	import spim0_pkg::*;
	logic              valid;
	logic              ready;
	logic              sclk;
	logic              mosi;
	logic              cs_n;
	logic              ready_res;
	logic [BYTE_W-1:0] rx_byte;
	logic              rx_valid;

	modport source (output valid, sclk, mosi, cs_n, ready_res, rx_byte, rx_valid,
		input ready);
	modport sink (input valid, sclk, mosi, cs_n, ready_res, rx_byte, rx_valid,
		output ready);
endinterface

interface spim0_cfg_if;
	import spim0_pkg::*;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[rtl/core/spim0_engine.sv]
`timescale 1ns / 1ps
// Bit-timing engine: SPI state registers and the per-tick next-state logic.
// Depends on spim0_pkg.
module spim0_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [spim0_pkg::HALF_W-1:0] half_period,
	input  spim0_pkg::req_t           req_in,
	output spim0_pkg::res_t           res_out,
	output spim0_pkg::eng_status_t    status
);
	import spim0_pkg::*;

	logic [PHASE_W-1:0]   phase_q,  phase_d;
	logic [BIT_IDX_W-1:0] bidx_q,   bidx_d;
	logic [HALF_W-1:0]    dcnt_q,   dcnt_d;
	logic [BYTE_W-1:0]    txsh_q,   txsh_d;
	logic [BYTE_W-1:0]    rxsh_q,   rxsh_d;
	logic                 drive_q,  drive_d;
	logic                 close_q,  close_d;
	logic                 sclk_q,   sclk_d;
	logic                 mosi_q,   mosi_d;
	logic                 cs_n_q,   cs_n_d;
	logic [HALF_W-1:0]    half;
	logic [HALF_W-1:0]    dcnt_dec;
	logic                 rx_valid;
	logic [BYTE_W-1:0]    rx_out;
	logic                 start_bit;

	// zero half period behaves as one
	assign half     = (half_period == '0) ? HALF_W'(1) : half_period;
	assign dcnt_dec = (dcnt_q != '0) ? dcnt_q - HALF_W'(1) : '0;

	always_comb begin
		phase_d   = phase_q;
		bidx_d    = bidx_q;
		dcnt_d    = dcnt_q;
		txsh_d    = txsh_q;
		rxsh_d    = rxsh_q;
		drive_d   = drive_q;
		close_d   = close_q;
		sclk_d    = sclk_q;
		mosi_d    = mosi_q;
		cs_n_d    = cs_n_q;
		rx_valid  = 1'b0;
		rx_out    = '0;
		start_bit = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (req_in.kind) begin
				txsh_d  = req_in.tx_byte;
				rxsh_d  = '0;
				drive_d = req_in.drive_out;
				close_d = req_in.close_frame;
				bidx_d  = '0;
				if (req_in.open_frame) begin
					mosi_d  = 1'b0;
					sclk_d  = 1'b0;
					cs_n_d  = 1'b0;
					phase_d = PH_SETUP;
					dcnt_d  = half;
				end else begin
					start_bit = 1'b1;
				end
			end
		end else begin
			dcnt_d = dcnt_dec;
			if (dcnt_dec == '0) begin
				case (phase_q)
					PH_SETUP: begin
						if (bidx_q == '0) begin
							bidx_d = BIT_IDX_W'(1);
							dcnt_d = half;
						end else begin
							bidx_d    = '0;
							start_bit = 1'b1;
						end
					end
					PH_LOW: begin
						sclk_d  = 1'b1;
						rxsh_d  = {rxsh_q[BYTE_W-2:0], req_in.miso};
						phase_d = PH_HIGH;
						dcnt_d  = half;
					end
					PH_HIGH: begin
						if (bidx_q != LAST_BIT) begin
							bidx_d    = bidx_q + BIT_IDX_W'(1);
							start_bit = 1'b1;
						end else begin
							rx_valid = 1'b1;
							rx_out   = rxsh_q;
							bidx_d   = '0;
							if (close_q) begin
								sclk_d  = 1'b0;
								phase_d = PH_CLOSE;
								dcnt_d  = half;
							end else begin
								phase_d = PH_IDLE;
							end
						end
					end
					PH_CLOSE: begin
						if (bidx_q == '0) begin
							bidx_d = BIT_IDX_W'(1);
							dcnt_d = half;
						end else begin
							bidx_d  = '0;
							cs_n_d  = 1'b1;
							mosi_d  = 1'b0;
							phase_d = PH_IDLE;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end

		// start of a bit: clock low, data out from the shifter's MSB when driving
		if (start_bit) begin
			sclk_d = 1'b0;
			if (drive_d)
				mosi_d = txsh_d[BYTE_W-1];
			txsh_d  = {txsh_d[BYTE_W-2:0], 1'b0};
			phase_d = PH_LOW;
			dcnt_d  = half;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bidx_q  <= '0;
			dcnt_q  <= '0;
			txsh_q  <= '0;
			rxsh_q  <= '0;
			drive_q <= 1'b0;
			close_q <= 1'b0;
			sclk_q  <= 1'b0;
			mosi_q  <= 1'b0;
			cs_n_q  <= 1'b1;
		end else if (en) begin
			phase_q <= phase_d;
			bidx_q  <= bidx_d;
			dcnt_q  <= dcnt_d;
			txsh_q  <= txsh_d;
			rxsh_q  <= rxsh_d;
			drive_q <= drive_d;
			close_q <= close_d;
			sclk_q  <= sclk_d;
			mosi_q  <= mosi_d;
			cs_n_q  <= cs_n_d;
		end
	end

	always_comb begin
		res_out.sclk      = sclk_d;
		res_out.mosi      = mosi_d;
		res_out.cs_n      = cs_n_d;
		res_out.ready_res = (phase_d == PH_IDLE);
		res_out.rx_byte   = rx_out;
		res_out.rx_valid  = rx_valid;
	end

	assign status.busy     = (phase_q != PH_IDLE);
	assign status.delay_nz = (dcnt_q != '0);

endmodule

[rtl/core/spi_master_mode0_core.sv]
`timescale 1ns / 1ps
// Top level of the mode-0 SPI master (MSB first, clock idles low).
// Depends on spim0_pkg, spim0_ifs and spim0_engine.
//
// Use:
//   req : one request per bit-timing tick. It carries the sampled MISO level
//         and, with kind set, a byte request (tx_byte, drive_out, open_frame,
//         close_frame). A byte request is only taken while ready_res was 1.
//   res : exactly one result per request: pin levels sclk/mosi/cs_n after
//         that tick, ready_res, and rx_byte/rx_valid on the tick a byte ends.
//   cfg : half_period_ticks write; always ready. Write only while idle.
// Timing:
//   A request passes an input register (_s1) and the engine's state update
//   into the result register (res_q). One request per cycle is sustained
//   while the result side stays ready; the engine's state registers close a
//   loop through the next-state logic, so each tick's update completes in
//   the cycle it advances.
// Reset: select high, sclk and mosi low, engine idle, half period 1, both
//   pipeline slots empty.
// Stall: while the result register waits, the input stage holds one more
//   request and req.ready drops once it is full; nothing is lost or repeated.
module spi_master_mode0_core (
	input logic        clk,
	input logic        arst_n,
	spim0_req_if.sink   req,
	spim0_res_if.source res,
	spim0_cfg_if.sink   cfg
);
	import spim0_pkg::*;

	logic              valid_s1;
	req_t              req_s1;
	logic              res_valid_q;
	res_t              res_q;
	logic [HALF_W-1:0] half_q;
	logic              advance;
	res_t              eng_res;
	eng_status_t       eng_st;

	// the input stage moves on when the result register is free or draining
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_W'(1);
		end else if (cfg.valid) begin
			half_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.kind        <= req.kind;
			req_s1.tx_byte     <= req.tx_byte;
			req_s1.drive_out   <= req.drive_out;
			req_s1.open_frame  <= req.open_frame;
			req_s1.close_frame <= req.close_frame;
			req_s1.miso        <= req.miso;
		end
	end

	spim0_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.half_period (half_q),
		.req_in      (req_s1),
		.res_out     (eng_res),
		.status      (eng_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= eng_res;
	end

	assign res.valid     = res_valid_q;
	assign res.sclk      = res_q.sclk;
	assign res.mosi      = res_q.mosi;
	assign res.cs_n      = res_q.cs_n;
	assign res.ready_res = res_q.ready_res;
	assign res.rx_byte   = res_q.rx_byte;
	assign res.rx_valid  = res_q.rx_valid;

	// an advancing tick always leaves a result behind
	a_adv_fills_res: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register empty after engine advance");

	// any active phase keeps a pending delay
	a_busy_delay: assert property (@(posedge clk) disable iff (!arst_n)
		eng_st.busy |-> eng_st.delay_nz)
		else $error("engine busy with zero delay count");

	// received byte field is clear on ticks with no completed byte
	a_rx_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.rx_valid) |-> (res_q.rx_byte == '0))
		else $error("rx_byte non-zero without rx_valid");

	// a full input stage never takes a request unless it moves on
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> $stable(req_s1))
		else $error("input stage overwritten while stalled");

endmodule
